FILE: rtl/ipv4hv_pkg.sv
// IPv4 header check package: verdict codes, register indexes, beat and result types.
// Shared by every module of ipv4_header_validate_classify; depends on nothing.
package ipv4hv_pkg;

	typedef enum logic [3:0] {
		V_TCP      = 4'd0,
		V_ICMP     = 4'd1,
		V_OTHER    = 4'd2,
		V_SMALL    = 4'd3,
		V_VERSION  = 4'd4,
		V_HLEN     = 4'd5,
		V_CKSUM    = 4'd6,
		V_LEN      = 4'd7,
		V_SHORT    = 4'd8,
		V_NOTLOCAL = 4'd9,
		V_FRAG     = 4'd10
	} verdict_t;

	localparam logic [1:0] CFG_CKSUM_EN = 2'd0;
	localparam logic [1:0] CFG_ADDR_LO  = 2'd1;
	localparam logic [1:0] CFG_ADDR_HI  = 2'd2;

	localparam logic [3:0]  IP_VERSION   = 4'd4;
	localparam logic [3:0]  MIN_IHL      = 4'd5;
	localparam logic [15:0] MIN_FRAME    = 16'd20;
	localparam logic [15:0] CKSUM_ZERO   = 16'hffff;
	localparam logic [15:0] FRAG_MASK    = 16'hbfff;
	localparam logic [7:0]  PROTO_TCP    = 8'd6;
	localparam logic [7:0]  PROTO_ICMP   = 8'd1;
	localparam logic [3:0]  WIDX_FRAG    = 4'd1;
	localparam logic [3:0]  WIDX_PROTO   = 4'd2;
	localparam logic [3:0]  WIDX_DEST    = 4'd4;

	typedef struct packed {
		logic        cksum_en;
		logic [31:0] addr_lo;
		logic [31:0] addr_hi;
	} cfg_t;

	typedef struct packed {
		logic [31:0] header_word;
		logic        first_word;
		logic [15:0] frame_len;
	} hdr_beat_t;

	typedef struct packed {
		verdict_t    verdict;
		logic [5:0]  header_bytes;
		logic [15:0] payload_len;
		logic [7:0]  protocol;
		logic [31:0] dest_addr;
	} result_t;

	function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[15:0] + {15'd0, s[16]};
	endfunction

endpackage

FILE: rtl/ipv4hv_cfg.sv
// Configuration register file: checksum enable and local address range.
// Depends on ipv4hv_pkg.
module ipv4hv_cfg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	output logic               cfg_ready,
	output ipv4hv_pkg::cfg_t   cfg
);
	import ipv4hv_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cksum_en <= 1'b1;
			cfg_q.addr_lo  <= '0;
			cfg_q.addr_hi  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_CKSUM_EN: cfg_q.cksum_en <= cfg_data[0];
				CFG_ADDR_LO:  cfg_q.addr_lo  <= cfg_data;
				CFG_ADDR_HI:  cfg_q.addr_hi  <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

FILE: rtl/ipv4hv_parse.sv
// Header field capture, running checksum and verdict logic for one beat.
// Depends on ipv4hv_pkg.
module ipv4hv_parse (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ipv4hv_pkg::cfg_t       cfg,
	input  ipv4hv_pkg::hdr_beat_t  beat,
	input  logic                   fire,
	output logic                   has_res,
	output ipv4hv_pkg::result_t    res
);
	import ipv4hv_pkg::*;

	logic [15:0] sum_q, sum_n;
	logic [3:0]  widx_q, widx_n;
	logic [3:0]  ihl_q, ihl_n;
	logic [15:0] total_q, total_n;
	logic [15:0] buf_q, buf_n;
	logic [15:0] frag_q, frag_n;
	logic [7:0]  proto_q, proto_n;
	logic [15:0] stored_q, stored_n;
	logic [31:0] dest_q, dest_n;
	logic        done_q, done_n;

	always_comb begin
		logic [15:0] hi, lo, expect_sum;
		logic [5:0]  hbytes;
		logic        last;
		verdict_t    v;
		hi = beat.header_word[31:16];
		lo = beat.header_word[15:0];
		sum_n    = sum_q;
		widx_n   = widx_q;
		ihl_n    = ihl_q;
		total_n  = total_q;
		buf_n    = buf_q;
		frag_n   = frag_q;
		proto_n  = proto_q;
		stored_n = stored_q;
		dest_n   = dest_q;
		done_n   = done_q;
		has_res  = 1'b0;
		v        = V_OTHER;
		res      = '0;
		expect_sum = '0;
		hbytes   = '0;
		last     = 1'b0;
		if (beat.first_word) begin
			buf_n    = beat.frame_len;
			ihl_n    = beat.header_word[27:24];
			total_n  = lo;
			frag_n   = '0;
			proto_n  = '0;
			stored_n = '0;
			dest_n   = '0;
			sum_n    = ones_add(hi, lo);
			widx_n   = 4'd1;
			done_n   = 1'b0;
			if (beat.frame_len < MIN_FRAME) begin
				has_res = 1'b1;
				v = V_SMALL;
			end else if (beat.header_word[31:28] != IP_VERSION) begin
				has_res = 1'b1;
				v = V_VERSION;
			end else if (ihl_n < MIN_IHL ||
					{10'd0, ihl_n, 2'b00} > beat.frame_len) begin
				has_res = 1'b1;
				v = V_HLEN;
			end
			if (has_res) begin
				done_n = 1'b1;
			end
			res.verdict      = v;
			res.header_bytes = {ihl_n, 2'b00};
		end else if (!done_q) begin
			case (widx_q)
				WIDX_FRAG: begin
					frag_n = lo;
					sum_n  = ones_add(ones_add(sum_q, hi), lo);
				end
				WIDX_PROTO: begin
					proto_n  = hi[7:0];
					stored_n = lo;
					sum_n    = ones_add(sum_q, hi);
				end
				WIDX_DEST: begin
					dest_n = beat.header_word;
					sum_n  = ones_add(ones_add(sum_q, hi), lo);
				end
				default: sum_n = ones_add(ones_add(sum_q, hi), lo);
			endcase
			last   = ({1'b0, widx_q} + 5'd1) >= {1'b0, ihl_q};
			hbytes = {ihl_q, 2'b00};
			expect_sum = (stored_n == 16'd0) ? CKSUM_ZERO : stored_n;
			if (cfg.cksum_en && (~sum_n != expect_sum))
				v = V_CKSUM;
			else if (total_n < {10'd0, hbytes})
				v = V_LEN;
			else if (buf_n < total_n)
				v = V_SHORT;
			else if (cfg.addr_lo > cfg.addr_hi || dest_n < cfg.addr_lo ||
					dest_n > cfg.addr_hi)
				v = V_NOTLOCAL;
			else if ((frag_n & FRAG_MASK) != 16'd0)
				v = V_FRAG;
			else if (proto_n == PROTO_TCP)
				v = V_TCP;
			else if (proto_n == PROTO_ICMP)
				v = V_ICMP;
			else
				v = V_OTHER;
			if (last) begin
				has_res = 1'b1;
				done_n  = 1'b1;
			end else begin
				widx_n = widx_q + 4'd1;
			end
			res.verdict      = v;
			res.header_bytes = hbytes;
			res.protocol     = proto_n;
			res.dest_addr    = dest_n;
			if (v == V_TCP || v == V_ICMP || v == V_OTHER)
				res.payload_len = total_n - {10'd0, hbytes};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q    <= '0;
			widx_q   <= '0;
			ihl_q    <= '0;
			total_q  <= '0;
			buf_q    <= '0;
			frag_q   <= '0;
			proto_q  <= '0;
			stored_q <= '0;
			dest_q   <= '0;
			done_q   <= 1'b1;
		end else if (fire) begin
			sum_q    <= sum_n;
			widx_q   <= widx_n;
			ihl_q    <= ihl_n;
			total_q  <= total_n;
			buf_q    <= buf_n;
			frag_q   <= frag_n;
			proto_q  <= proto_n;
			stored_q <= stored_n;
			dest_q   <= dest_n;
			done_q   <= done_n;
		end
	end

endmodule

FILE: rtl/ipv4hv_outbuf.sv
// Result register towards the output channel, with valid/stall handshake.
// Depends on ipv4hv_pkg.
module ipv4hv_outbuf (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  ipv4hv_pkg::result_t  res,
	input  logic                 out_stall,
	output logic                 out_valid,
	output logic                 free,
	output ipv4hv_pkg::result_t  res_q
);
	import ipv4hv_pkg::*;

	logic valid_q;

	assign out_valid = valid_q;
	assign free = !valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

endmodule

FILE: rtl/ipv4_header_validate_classify.sv
// IPv4 receive header check and classifier, top level.
// Depends on ipv4hv_pkg, ipv4hv_cfg, ipv4hv_parse and ipv4hv_outbuf.
//
// Usage:
//   Input channel (in_valid/in_stall): one 32-bit header word per beat, big-endian,
//   first_word marking word 0 of a packet, frame_len sampled on that word.
//   Output channel (out_valid/out_stall): one verdict beat per packet, on word 0
//   for small/version/hlen failures, otherwise on word IHL-1.
//   Config channel (cfg_valid/cfg_ready): index 0 checksum enable, 1 and 2 the
//   local address range; always ready, write only while idle.
//   A word is held in the input register, checked combinationally, and its verdict is
//   loaded into the output register. Throughput: one word per cycle while in_stall is low.
//   Words that give no verdict keep flowing while a verdict waits at the output;
//   a word that gives a verdict waits in the input register until the output
//   register frees, and in_stall is raised behind it.
//   Reset: nothing in progress, checksum check enabled, address range 0..0;
//   words before the next first word are dropped.
module ipv4_header_validate_classify (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] header_word,
	input  logic        first_word,
	input  logic [15:0] frame_len,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  verdict,
	output logic [5:0]  header_bytes,
	output logic [15:0] payload_len,
	output logic [7:0]  protocol,
	output logic [31:0] dest_addr,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import ipv4hv_pkg::*;

	cfg_t      cfg;
	hdr_beat_t beat_s1;
	logic      valid_s1;
	logic      adv_s1;
	logic      has_res;
	logic      out_free;
	logic      in_take;
	result_t   res;
	result_t   res_q;

	ipv4hv_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg_ready (cfg_ready),
		.cfg       (cfg)
	);

	assign adv_s1   = valid_s1 && (!has_res || out_free);
	assign in_stall = valid_s1 && !adv_s1;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			beat_s1.header_word <= header_word;
			beat_s1.first_word  <= first_word;
			beat_s1.frame_len   <= frame_len;
		end
	end

	ipv4hv_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.beat    (beat_s1),
		.fire    (adv_s1),
		.has_res (has_res),
		.res     (res)
	);

	ipv4hv_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (adv_s1 && has_res),
		.res       (res),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.free      (out_free),
		.res_q     (res_q)
	);

	assign verdict      = res_q.verdict;
	assign header_bytes = res_q.header_bytes;
	assign payload_len  = res_q.payload_len;
	assign protocol     = res_q.protocol;
	assign dest_addr    = res_q.dest_addr;

`ifndef NO_ASSERTIONS
	a_res_lands: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && has_res |=> out_valid)
		else $error("verdict beat lost at output register");

	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && has_res && !out_free)
		else $error("input stalled without a blocked verdict");

	a_fail_no_payload: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && res_q.verdict != V_TCP && res_q.verdict != V_ICMP &&
		res_q.verdict != V_OTHER |-> res_q.payload_len == 16'd0)
		else $error("payload length on a drop verdict");

	a_cfg_en: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready && cfg_index == CFG_CKSUM_EN |=>
		cfg.cksum_en == $past(cfg_data[0]))
		else $error("checksum enable write not taken");
`endif

endmodule
